FILE: hdl/string_key_value_store_core_assert.svh
// Assertion macros for the store's core RTL file.
`ifndef STRING_KEY_VALUE_STORE_CORE_ASSERT_SVH
`define STRING_KEY_VALUE_STORE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Antecedent true at an edge implies consequent at the same edge.
`define SKV_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("skv assertion failed");

// Antecedent true at an edge implies consequent at the next edge.
`define SKV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("skv assertion failed");

`else

`define SKV_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SKV_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/skv_pkg.sv
// Types, codes and defaults of the string key and value store.
`default_nettype none

package skv_pkg;

	localparam int ENTRIES_DEF   = 32;
	localparam int KEY_CHARS_DEF = 8;

	localparam logic [1:0] FUNC_SET = 2'd0;
	localparam logic [1:0] FUNC_GET = 2'd1;
	localparam logic [1:0] FUNC_DEL = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_OVERLONG  = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [1:0]         func;
		logic [63:0]        key_bytes;
		logic [3:0]         key_length;
		logic signed [31:0] new_value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] read_value;
	} rsp_t;

	// One memory entry: valid flag, zero-padded key, value.
	typedef struct packed {
		logic        valid;
		logic [63:0] key;
		logic [31:0] value;
	} slot_t;

endpackage

`default_nettype wire

FILE: hdl/skv_req_if.sv
// Request channel: valid, ready and one request word.
`default_nettype none

interface skv_req_if;
	logic          valid;
	logic          ready;
	skv_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/skv_rsp_if.sv
// Response channel: valid, ready and one response word.
`default_nettype none

interface skv_rsp_if;
	logic          valid;
	logic          ready;
	skv_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/skv_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module skv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

`default_nettype wire

FILE: hdl/string_key_value_store_core.sv
// Top level of the string key and value store.
//
// A bounded store of up to ENTRIES pairs of short string key (at most KEY_CHARS
// characters, packed little-endian into a zero-padded 64-bit field) and 32-bit
// signed value. Each request word is set (insert or update), get or delete and
// yields exactly one response word with a status and, for a successful get, the
// stored value. All entries sit in one synchronous RAM; every request reads the
// whole RAM, one entry per cycle, to find a matching key and the first free
// entry, then writes back at most one entry. A new request is accepted only
// once the previous one has passed its scan and write-back and loaded its
// response into the output register; the single RAM read port sets this
// pace. The response sits in an output register, so the next request may
// start while a response waits to be taken. After reset a clearing pass
// writes every entry invalid, one per cycle; no request is accepted until
// it ends.
`default_nettype none

`include "string_key_value_store_core_assert.svh"

module string_key_value_store_core #(
	parameter int ENTRIES   = skv_pkg::ENTRIES_DEF,
	parameter int KEY_CHARS = skv_pkg::KEY_CHARS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	skv_req_if.sink   req,
	skv_rsp_if.source rsp
);
	import skv_pkg::*;

	localparam int              AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [AW-1:0]   LAST    = AW'(ENTRIES - 1);
	localparam logic [3:0]      KEY_MAX = 4'(KEY_CHARS);

	// Controller states.
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_LAST  = 3'd3;
	localparam logic [2:0] ST_WRITE = 3'd4;

	logic [2:0]    state_q;
	logic [AW-1:0] cnt_q;

	// Captured request.
	logic [1:0]  func_q;
	logic [63:0] key_q;
	logic        fits_q;
	logic [31:0] val_q;

	// Scan results.
	logic          rd_pend_s1;
	logic [AW-1:0] rd_idx_s1;
	logic          match_found_q;
	logic [AW-1:0] match_idx_q;
	logic [31:0]   match_val_q;
	logic          free_found_q;
	logic [AW-1:0] free_idx_q;

	// Output register.
	logic out_valid_q;
	rsp_t out_q;

	// RAM port signals.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	slot_t         ram_wdata;
	logic [AW-1:0] ram_raddr;
	slot_t         ram_rdata;

	logic        accept;
	logic        can_finish;
	logic        finish;
	logic [63:0] key_masked;
	logic        key_fits;
	logic        hit;
	logic        empty;

	// Decision after the scan.
	logic [1:0]  status_d;
	logic [31:0] rd_d;
	logic        do_write;
	logic [AW-1:0] wr_idx;
	slot_t       wr_slot;

	skv_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req.ready  = (state_q == ST_IDLE);
	assign accept     = req.valid && req.ready;
	assign rsp.valid  = out_valid_q;
	assign rsp.data   = out_q;
	assign can_finish = !out_valid_q || rsp.ready;
	assign finish     = (state_q == ST_WRITE) && can_finish;

	// Keep only the low key_length bytes; an overlong key matches nothing.
	assign key_fits = (req.data.key_length <= KEY_MAX);
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			key_masked[8*b +: 8] = (key_fits && (4'(b) < req.data.key_length)) ?
				req.data.key_bytes[8*b +: 8] : 8'h00;
		end
	end

	// Compare the entry returned by the RAM this cycle; first hit and first
	// free entry win.
	assign hit   = rd_pend_s1 && ram_rdata.valid && fits_q &&
	               (ram_rdata.key == key_q) && !match_found_q;
	assign empty = rd_pend_s1 && !ram_rdata.valid && !free_found_q;

	// Work out status, read value and write-back once the scan is complete.
	always_comb begin
		status_d = STAT_NOT_FOUND;
		rd_d     = '0;
		do_write = 1'b0;
		wr_idx   = match_idx_q;
		wr_slot  = '{valid: 1'b1, key: key_q, value: val_q};
		case (func_q)
			FUNC_SET: begin
				if (!fits_q) begin
					status_d = STAT_OVERLONG;
				end else if (match_found_q) begin
					status_d = STAT_OK;
					do_write = 1'b1;
				end else if (free_found_q) begin
					status_d = STAT_OK;
					do_write = 1'b1;
					wr_idx   = free_idx_q;
				end else begin
					status_d = STAT_FULL;
				end
			end
			FUNC_GET: begin
				if (match_found_q) begin
					status_d = STAT_OK;
					rd_d     = match_val_q;
				end
			end
			FUNC_DEL: begin
				if (match_found_q) begin
					status_d      = STAT_OK;
					do_write      = 1'b1;
					wr_slot.valid = 1'b0;
				end
			end
			default: begin
				status_d = STAT_NOT_FOUND;
			end
		endcase
	end

	// RAM access: sweep writes during clearing, reads during the scan, at most
	// one write-back together with the response.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = '0;
		ram_raddr = cnt_q;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_WRITE: begin
				ram_we    = finish && do_write;
				ram_waddr = wr_idx;
				ram_wdata = wr_slot;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			cnt_q         <= '0;
			rd_pend_s1    <= 1'b0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			rd_pend_s1 <= (state_q == ST_SCAN);
			if (hit) begin
				match_found_q <= 1'b1;
			end
			if (empty) begin
				free_found_q <= 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						// Start a fresh scan from entry zero.
						cnt_q         <= '0;
						match_found_q <= 1'b0;
						free_found_q  <= 1'b0;
						state_q       <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					// Last entry is compared this cycle.
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					// Hold until the output register is free.
					if (can_finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req.data.func;
			key_q  <= key_masked;
			fits_q <= key_fits;
			val_q  <= req.data.new_value;
		end
		rd_idx_s1 <= cnt_q;
		if (hit) begin
			match_idx_q <= rd_idx_s1;
			match_val_q <= ram_rdata.value;
		end
		if (empty) begin
			free_idx_q <= rd_idx_s1;
		end
		if (finish) begin
			out_q.status     <= status_d;
			out_q.read_value <= rd_d;
		end
	end

	// A response appears only right after the write-back state.
	`SKV_ASSERT_SAME(a_rsp_after_write, clk, arst_n, $rose(out_valid_q), $past(state_q) == ST_WRITE)
	// An accepted request always starts a scan.
	`SKV_ASSERT_NEXT(a_accept_scans, clk, arst_n, accept, state_q == ST_SCAN)
	// The free entry found is never the entry holding the key.
	`SKV_ASSERT_SAME(a_free_not_match, clk, arst_n, match_found_q && free_found_q, match_idx_q != free_idx_q)

endmodule

`default_nettype wire

FILE: tb/skv_store_scoreboard_pkg.sv
// Shadow copy of the key and value store, and the scoreboard that checks its replies.
package skv_store_scoreboard_pkg;

	import skv_pkg::*;

	localparam int SLOTS     = ENTRIES_DEF;
	localparam int KEY_LIMIT = KEY_CHARS_DEF;

	// Keep the low len bytes of a key word.
	function automatic logic [63:0] key_mask(input logic [3:0] len);
		if (len >= 4'd8)
			return '1;
		return (64'd1 << (8 * len)) - 64'd1;
	endfunction

	class kv_store_scoreboard;
		bit          shadow_live [SLOTS];
		logic [63:0] shadow_key [SLOTS];
		logic [31:0] shadow_value [SLOTS];
		rsp_t        pending_replies [$];
		int          errors;
		int          replies_checked;
		int          outcome_count [4];

		function new();
			foreach (shadow_live[i])
				shadow_live[i] = 1'b0;
			errors = 0;
			replies_checked = 0;
			foreach (outcome_count[i])
				outcome_count[i] = 0;
		endfunction

		function int pending();
			return pending_replies.size();
		endfunction

		// Apply one accepted request word to the shadow store and queue its reply.
		function void note_request(input req_t w);
			bit          fits;
			logic [63:0] key;
			int          hit;
			int          hole;
			int          i;
			rsp_t        reply;

			fits = w.key_length <= KEY_LIMIT;
			key = fits ? (w.key_bytes & key_mask(w.key_length)) : '0;
			hit = -1;
			hole = -1;
			for (i = 0; i < SLOTS; i++) begin
				if (shadow_live[i]) begin
					if (fits && hit < 0 && shadow_key[i] == key)
						hit = i;
				end else if (hole < 0) begin
					hole = i;
				end
			end

			reply.status = STAT_NOT_FOUND;
			reply.read_value = '0;
			case (w.func)
				FUNC_SET: begin
					if (!fits) begin
						reply.status = STAT_OVERLONG;
					end else if (hit >= 0) begin
						shadow_value[hit] = w.new_value;
						reply.status = STAT_OK;
					end else if (hole >= 0) begin
						shadow_live[hole] = 1'b1;
						shadow_key[hole] = key;
						shadow_value[hole] = w.new_value;
						reply.status = STAT_OK;
					end else begin
						reply.status = STAT_FULL;
					end
				end
				FUNC_GET: begin
					if (hit >= 0) begin
						reply.read_value = shadow_value[hit];
						reply.status = STAT_OK;
					end
				end
				FUNC_DEL: begin
					if (hit >= 0) begin
						shadow_live[hit] = 1'b0;
						reply.status = STAT_OK;
					end
				end
				default: ;
			endcase
			outcome_count[reply.status]++;
			pending_replies.push_back(reply);
		endfunction

		task report(input string msg);
			errors++;
			if (errors <= 100)
				$display("[%0t] MISMATCH: %s", $time, msg);
		endtask

		// Compare one accepted reply word with the oldest queued one.
		task check_reply(input rsp_t got);
			rsp_t want;

			if (pending_replies.size() == 0) begin
				report($sformatf("unexpected reply: status %0d value %0d",
					got.status, got.read_value));
				return;
			end
			want = pending_replies.pop_front();
			replies_checked++;
			if (got.status !== want.status)
				report($sformatf("reply %0d: status %0d, expected %0d",
					replies_checked, got.status, want.status));
			if (got.read_value !== want.read_value)
				report($sformatf("reply %0d: read_value %0d, expected %0d",
					replies_checked, got.read_value, want.read_value));
		endtask
	endclass

endpackage

FILE: tb/string_key_value_store_core_tb.sv
// Self-checking testbench of the string key and value store core.
module string_key_value_store_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import skv_pkg::*;
	import skv_store_scoreboard_pkg::*;

	localparam int          ENTRIES        = ENTRIES_DEF;
	localparam int          KEY_CHARS      = KEY_CHARS_DEF;
	// The block never decodes this opcode; it must answer not found.
	localparam logic [1:0]  FUNC_UNUSED    = 2'd3;
	localparam int          POOL_SIZE      = 48;
	localparam int          PHASES         = 6;
	localparam int          PHASE_ITEMS    = 150;
	// Reply stalls and request gaps below reach twice one request's length.
	// Allow the clearing pass plus many times the worst quiet stretch.
	localparam int          QUIET_LIMIT    = 4000;
	localparam int          SETTLE_CYCLES  = 3 * (ENTRIES + 3);

	logic clk;
	logic arst_n;

	skv_req_if req_link ();
	skv_rsp_if rsp_link ();

	string_key_value_store_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_link),
		.rsp    (rsp_link)
	);

	kv_store_scoreboard sb;

	// Stimulus knobs, changed only between phases with the block idle; counters.
	int tx_idle_pct;
	int rx_stall_pct;
	int stall_left;
	int quiet_cycles;
	int words_sent;
	int directed_sent;

	// Key pool: each entry is a clean, zero-padded key word and its length.
	logic [63:0] pool_key [POOL_SIZE];
	logic [3:0]  pool_len [POOL_SIZE];

	// Per-phase shape: how many pool keys are live, operation mix, idling.
	// A pool wider than the table pushes sets into table full; the small
	// delete-heavy phase drains the table again.
	int phase_pool [PHASES]  = '{8, 40, 20, 48, 10, 36};
	int phase_set [PHASES]   = '{45, 55, 45, 40, 20, 55};
	int phase_del [PHASES]   = '{20, 10, 20, 20, 50, 15};
	int phase_tx [PHASES]    = '{0, 70, 0, 34, 0, 34};
	int phase_rx [PHASES]    = '{0, 0, 70, 34, 0, 34};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Reply side: check each accepted word, then pick ready for the next edge.
	// Stalls come in bursts of random length so that a held reply overlaps
	// every point of the next request's table walk.
	always @(posedge clk) begin
		if (rsp_link.valid && rsp_link.ready)
			sb.check_reply(rsp_link.data);
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_link.ready <= 1'b0;
		end else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct) begin
			stall_left <= $urandom_range(2 * ENTRIES + 6);
			rsp_link.ready <= 1'b0;
		end else begin
			rsp_link.ready <= 1'b1;
		end
	end

	// Watchdog: end the run if no word moves on either channel for too long.
	always @(posedge clk) begin
		if ((req_link.valid && req_link.ready) || (rsp_link.valid && rsp_link.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[%0t] watchdog: no word moved for %0d cycles", $time, QUIET_LIMIT);
			$display("string_key_value_store_core test failed");
			$finish;
		end
	end

	function automatic req_t make_word(input logic [1:0] func, input logic [63:0] bytes,
			input logic [3:0] len, input logic [31:0] value);
		req_t w;

		w.func = func;
		w.key_bytes = bytes;
		w.key_length = len;
		w.new_value = value;
		return w;
	endfunction

	// Present one request word and hold it until accepted. Valid stays high
	// across back-to-back words; lower it only when a gap is taken, so the
	// signal never sees two assignments in one step.
	task automatic send_word(input req_t w);
		int gap;

		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			gap = $urandom_range(1, 2 * ENTRIES + 6);
			req_link.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_link.valid <= 1'b1;
		req_link.data <= w;
		do
			@(posedge clk);
		while (!req_link.ready);
		sb.note_request(w);
		words_sent++;
	endtask

	// Drop valid and hold off until every queued reply has been taken.
	task automatic drain_replies();
		req_link.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	// Build the key pool. Bytes are mostly nonzero, but an occasional zero
	// byte at the end of a key makes it alias the shorter key without it.
	task automatic build_pool();
		int          i;
		int          b;
		logic [63:0] word;
		logic [3:0]  len;

		for (i = 0; i < POOL_SIZE; i++) begin
			len = (i == 0) ? 4'd0 : 4'($urandom_range(1, KEY_CHARS));
			word = '0;
			for (b = 0; b < 8; b++)
				word[8 * b +: 8] = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
			pool_key[i] = word & key_mask(len);
			pool_len[i] = len;
		end
	endtask

	// Draw one random request. Most words name a pool key with a random
	// value; a few are noise: the unused opcode, overlong keys, or a fully
	// random eight-character key.
	function automatic req_t random_word(input int pool_n, input int set_pct,
			input int del_pct);
		int          pick;
		int          idx;
		logic [1:0]  func;
		logic [63:0] junk;
		logic [3:0]  len;

		pick = $urandom_range(99);
		idx = $urandom_range(pool_n - 1);
		len = pool_len[idx];
		junk = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'd0;
		if (pick < 5) begin
			case ($urandom_range(2))
				0: return make_word(FUNC_UNUSED, pool_key[idx] | (junk & ~key_mask(len)),
					len, $urandom);
				1: return make_word(2'($urandom_range(2)), {$urandom, $urandom},
					4'($urandom_range(KEY_CHARS + 1, 15)), $urandom);
				default: return make_word(2'($urandom_range(2)), {$urandom, $urandom},
					4'(KEY_CHARS), $urandom);
			endcase
		end
		if (pick < 5 + set_pct)
			func = FUNC_SET;
		else if (pick < 5 + set_pct + del_pct)
			func = FUNC_DEL;
		else
			func = FUNC_GET;
		return make_word(func, pool_key[idx] | (junk & ~key_mask(len)), len, $urandom);
	endfunction

	initial begin
		int p;
		int n;

		sb = new();
		words_sent = 0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		stall_left = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		req_link.valid = 1'b0;
		req_link.data = '0;
		rsp_link.ready = 1'b0;

		// Hold reset, then release it on an edge. The clearing pass that
		// follows simply shows up as ready low on the first word.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words: empty key, key extremes, masking of unused bytes,
		// zero byte ending a key, overlong keys, the unused opcode, update,
		// delete and repeated delete.
		send_word(make_word(FUNC_GET, 64'd0, 4'd0, 32'd0));
		send_word(make_word(FUNC_SET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'h7FFF_FFFF));
		send_word(make_word(FUNC_GET, 64'd0, 4'd0, 32'd5));
		send_word(make_word(FUNC_SET, 64'hA5A5_5A5A_FF63_6261, 4'd3, 32'h8000_0000));
		send_word(make_word(FUNC_GET, 64'h0000_0000_0063_6261, 4'd3, 32'd0));
		send_word(make_word(FUNC_GET, 64'h0000_0000_0063_6261, 4'd4, 32'd0));
		send_word(make_word(FUNC_GET, 64'h0000_0000_0063_6261, 4'd2, 32'd0));
		send_word(make_word(FUNC_SET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hFFFF_FFFF));
		send_word(make_word(FUNC_GET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'd0));
		send_word(make_word(FUNC_SET, 64'hFFFF_FFFF_FFFF_FFFF, 4'(KEY_CHARS + 1), 32'd1));
		send_word(make_word(FUNC_SET, 64'h0000_0000_0000_0041, 4'd15, 32'd2));
		send_word(make_word(FUNC_GET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'd0));
		send_word(make_word(FUNC_DEL, 64'hFFFF_FFFF_FFFF_FFFF, 4'(KEY_CHARS + 1), 32'd0));
		send_word(make_word(FUNC_UNUSED, 64'h0000_0000_0063_6261, 4'd3, 32'h1234_5678));
		send_word(make_word(FUNC_SET, 64'h0000_0000_0063_6261, 4'd3, 32'd1));
		send_word(make_word(FUNC_GET, 64'hFFFF_FFFF_FF63_6261, 4'd3, 32'd0));
		send_word(make_word(FUNC_DEL, 64'h0000_0000_0063_6261, 4'd3, 32'd0));
		send_word(make_word(FUNC_DEL, 64'h0000_0000_0063_6261, 4'd3, 32'd0));
		send_word(make_word(FUNC_GET, 64'h0000_0000_0063_6261, 4'd3, 32'd0));
		send_word(make_word(FUNC_SET, 64'h8000_0000_0000_0000, 4'd8, 32'h5555_5555));
		send_word(make_word(FUNC_GET, 64'h8000_0000_0000_0000, 4'd7, 32'd0));
		send_word(make_word(FUNC_DEL, 64'd0, 4'd0, 32'd0));
		directed_sent = words_sent;

		// Hold off until the directed replies are all in.
		drain_replies();
		build_pool();

		// Random phases, each ending with the sender paused until the block
		// has answered everything.
		for (p = 0; p < PHASES; p++) begin
			tx_idle_pct = phase_tx[p];
			rx_stall_pct = phase_rx[p];
			for (n = 0; n < PHASE_ITEMS; n++)
				send_word(random_word(phase_pool[p], phase_set[p], phase_del[p]));
			drain_replies();
		end

		// Give the block time to show any stray reply before the verdict.
		rx_stall_pct = 0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d replies never arrived", sb.pending()));

		$display("Sent %0d request words (%0d directed) through six idling and stall phases.",
			words_sent, directed_sent);
		$display("Outcomes checked: %0d ok, %0d overlong, %0d table full, %0d not found.",
			sb.outcome_count[STAT_OK], sb.outcome_count[STAT_OVERLONG],
			sb.outcome_count[STAT_FULL], sb.outcome_count[STAT_NOT_FOUND]);
		if (sb.errors == 0) begin
			$display("string_key_value_store_core test passed");
		end else begin
			$display("string_key_value_store_core test failed");
		end
		$finish;
	end

endmodule
